// File: design/u2a_pkg.sv
// ============================================================================
// UTF-8 to ASCII sanitizer package
// Shared types and character constants for the sanitizer front, queue and back.
// ============================================================================
`default_nettype none

package u2a_pkg;

   // Replacement character for anything that is not plain ASCII.
   localparam logic [6:0] QMARK = 7'h3F;

   // Sequence lengths held in the expected-length register.
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   // One command from the front to the back: emit count characters, all of
   // them '?' except the final one, which is last_char.
   typedef struct packed {
      logic [2:0] count;
      logic [6:0] last_char;
      logic       chunk_end;
   } cmd_type;

endpackage

`default_nettype wire

// File: design/u2a_front.sv
// ============================================================================
// Sanitizer front end
// Accepts input bytes, tracks the pending UTF-8 sequence and turns each byte
// that releases characters into a command saying how many the back end emits.
// ============================================================================
`default_nettype none

module u2a_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_chunk_end,
   output logic                  req_full,
   input  wire logic             q_full,
   output logic                  cmd_valid,
   output u2a_pkg::cmd_type      cmd
);

   logic [2:0] exp_len_ff;
   logic [2:0] exp_len_in;
   logic [1:0] held_ff;
   logic [1:0] held_in;

   logic       accept;
   logic       is_cont;
   logic       pending;
   logic [2:0] held_plus;
   logic [2:0] flush_count;
   logic       fresh;
   logic [2:0] fresh_len;
   logic       fresh_emit;
   logic [6:0] last_char;

   assign accept   = req_push & ~q_full;
   assign req_full = q_full;

   assign is_cont   = (req_data_byte[7:6] == 2'b10);
   assign pending   = (exp_len_ff != u2a_pkg::LEN_NONE);
   assign held_plus = {1'b0, held_ff} + 3'd1;

   // Length of a sequence that this byte would open; none for ASCII and
   // for continuation or invalid bytes.
   always_comb begin
      fresh_len = u2a_pkg::LEN_NONE;
      if (req_data_byte[7:5] == 3'b110) begin
         fresh_len = u2a_pkg::LEN_TWO;
      end else if (req_data_byte[7:4] == 4'b1110) begin
         fresh_len = u2a_pkg::LEN_THREE;
      end else if (req_data_byte[7:3] == 5'b11110) begin
         fresh_len = u2a_pkg::LEN_FOUR;
      end
   end

   always_comb begin
      exp_len_in  = exp_len_ff;
      held_in     = held_ff;
      flush_count = 3'd0;
      fresh       = 1'b1;
      fresh_emit  = 1'b0;
      last_char   = u2a_pkg::QMARK;

      if (pending) begin
         if (is_cont) begin
            fresh = 1'b0;
            if (held_plus >= exp_len_ff) begin
               flush_count = 3'd1;
               exp_len_in  = u2a_pkg::LEN_NONE;
               held_in     = 2'd0;
            end else if (req_chunk_end) begin
               // Unfinished sequence at the chunk end: every byte becomes '?'.
               flush_count = held_plus;
               exp_len_in  = u2a_pkg::LEN_NONE;
               held_in     = 2'd0;
            end else begin
               held_in = held_plus[1:0];
            end
         end else begin
            // Broken sequence: the held bytes are flushed and this byte is
            // handled afresh below.
            flush_count = {1'b0, held_ff};
            exp_len_in  = u2a_pkg::LEN_NONE;
            held_in     = 2'd0;
         end
      end

      if (fresh) begin
         if (!req_data_byte[7]) begin
            fresh_emit = 1'b1;
            last_char  = req_data_byte[6:0];
         end else if (fresh_len == u2a_pkg::LEN_NONE || req_chunk_end) begin
            fresh_emit = 1'b1;
         end else begin
            exp_len_in = fresh_len;
            held_in    = 2'd1;
         end
      end
   end

   assign cmd.count     = flush_count + {2'b00, fresh_emit};
   assign cmd.last_char = last_char;
   assign cmd.chunk_end = req_chunk_end;
   assign cmd_valid     = accept & (cmd.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= u2a_pkg::LEN_NONE;
         held_ff    <= 2'd0;
      end else if (accept) begin
         exp_len_ff <= exp_len_in;
         held_ff    <= held_in;
      end
   end

endmodule

`default_nettype wire

// File: design/u2a_queue.sv
// ============================================================================
// Command queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
`default_nettype none

module u2a_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire u2a_pkg::cmd_type wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output u2a_pkg::cmd_type      rd_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u2a_pkg::cmd_type slot_ff [DEPTH];

   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          do_wr;
   logic          do_rd;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en & ~full;
   assign do_rd = rd_en & ~empty;

   assign rd_data = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
   assign count_in  = count_ff + CW'(do_wr) - CW'(do_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: design/u2a_back.sv
// ============================================================================
// Sanitizer back end
// Expands each command into its run of output characters, one per beat,
// from an output register that the consumer pops.
// ============================================================================
`default_nettype none

module u2a_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire u2a_pkg::cmd_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [6:0]            rsp_out_char,
   output logic                  rsp_last_of_run,
   output logic                  rsp_chunk_done
);

   logic             busy_ff;
   logic             busy_in;
   logic [2:0]       remain_ff;
   logic [2:0]       remain_in;
   u2a_pkg::cmd_type cmd_ff;
   logic             final_beat;
   logic             taken;

   assign final_beat = (remain_ff == 3'd1);
   assign taken      = busy_ff & rsp_pop;

   // The next command loads as soon as the current run's last beat leaves.
   assign q_pop = ~q_empty & (~busy_ff | (taken & final_beat));

   always_comb begin
      busy_in   = busy_ff;
      remain_in = remain_ff;
      if (q_pop) begin
         busy_in   = 1'b1;
         remain_in = q_data.count;
      end else if (taken) begin
         if (final_beat) begin
            busy_in = 1'b0;
         end else begin
            remain_in = remain_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= 3'd0;
      end else begin
         busy_ff   <= busy_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
   end

   assign rsp_empty       = ~busy_ff;
   assign rsp_out_char    = final_beat ? cmd_ff.last_char : u2a_pkg::QMARK;
   assign rsp_last_of_run = final_beat;
   assign rsp_chunk_done  = final_beat & cmd_ff.chunk_end;

endmodule

`default_nettype wire

// File: design/utf8_to_ascii_sanitizer_core.sv
// ============================================================================
// UTF-8 to ASCII sanitizer core
// Turns a chunked byte stream into 7-bit ASCII, replacing UTF-8 sequences and
// invalid bytes with '?'.
// ============================================================================
//
//   Channel   Direction  Ports                                  Beat
//   request   in         req_push / req_full                    one byte
//   response  out        rsp_pop / rsp_empty                    one character
//
// A byte is taken every cycle while the command queue has room; the front end
// classifies it in the cycle it arrives. The back end emits one character per
// cycle while the consumer pops, so a byte that releases several characters
// (up to four) holds the back end for its whole run while the queue absorbs
// following bytes. Reset clears the pending sequence, the queue and the output
// register. A command is held in the queue, then in the output register.
// ============================================================================
`default_nettype none

module utf8_to_ascii_sanitizer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_chunk_end,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_last_of_run,
   output logic            rsp_chunk_done
);

   logic             cmd_valid;
   u2a_pkg::cmd_type cmd;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   u2a_pkg::cmd_type q_data;

   u2a_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_chunk_end (req_chunk_end),
      .req_full      (req_full),
      .q_full        (q_full),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd)
   );

   u2a_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_valid),
      .wr_data (cmd),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   u2a_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_chunk_done  (rsp_chunk_done)
   );

endmodule

`default_nettype wire

// File: design/u2a_checker.sv
// ============================================================================
// Sanitizer port checker
// Watches the core's ports and flags results that break the output rules.
// ============================================================================
`default_nettype none

module u2a_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_push,
   input wire logic       req_full,
   input wire logic [7:0] req_data_byte,
   input wire logic       req_chunk_end,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [6:0] rsp_out_char,
   input wire logic       rsp_last_of_run,
   input wire logic       rsp_chunk_done
);

   // Nothing is shown in the cycle after a reset.
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response shown right after reset");

   // Only the final character of a run can be anything other than '?'.
   a_run_body_qmark : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last_of_run) |-> (rsp_out_char == u2a_pkg::QMARK))
      else $error("non-final character of a run is not a question mark");

   // The end of a chunk is always the end of a run.
   a_chunk_done_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_chunk_done) |-> rsp_last_of_run)
      else $error("chunk_done without last_of_run");

   // A stalled response beat holds its value.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_char) && $stable(rsp_last_of_run)
          && $stable(rsp_chunk_done)))
      else $error("stalled response beat changed");

endmodule

bind utf8_to_ascii_sanitizer_core u2a_checker u_u2a_checker (.*);

`default_nettype wire

// File: tb/sv/utf8_to_ascii_sanitizer_core_test.sv
// ============================================================================
// UTF-8 to ASCII sanitizer core testbench
// Drives byte beats into the sanitizer and checks every character beat
// against a predictor of the sanitizer kept in the bench. Directed tests cover
// plain ASCII, complete and broken sequences, stray bytes and chunk ends.
// Random tests mix well-formed sequences with noise under random idling on
// both sides, and a long receiver hold-off backs the core up into its input.
// ============================================================================
`default_nettype none

module utf8_to_ascii_sanitizer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_of_run;
      logic       chunk_done;
   } char_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_chunk_end = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_last_of_run;
   logic       rsp_chunk_done;

   // Predictor state: length of the open sequence and bytes of it seen so far.
   logic [2:0] open_length = u2a_pkg::LEN_NONE;
   logic [1:0] open_held = 2'd0;

   char_beat_type expected_chars[$];
   int         failures = 0;
   bit         sender_steady = 1'b0;
   bit         receiver_steady = 1'b0;
   int         receiver_hold = 0;

   utf8_to_ascii_sanitizer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_chunk_end   (req_chunk_end),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_chunk_done  (rsp_chunk_done)
   );

   always #5 clock = ~clock;

   function automatic void queue_char(input logic [6:0] ch);
      char_beat_type beat;
      beat.out_char = ch;
      beat.last_of_run = 1'b0;
      beat.chunk_done = 1'b0;
      expected_chars.push_back(beat);
   endfunction

   // Works out the characters released by one accepted byte.
   function automatic void predict_sanitized(input logic [7:0] value,
                                             input logic last_in_chunk);
      int         released;
      logic       fresh;
      logic [2:0] held;
      logic [2:0] lead_length;
      released = expected_chars.size();
      fresh = 1'b1;
      if (open_length != u2a_pkg::LEN_NONE) begin
         if (value[7:6] == 2'b10) begin
            held = {1'b0, open_held} + 3'd1;
            fresh = 1'b0;
            if (held >= open_length) begin
               queue_char(u2a_pkg::QMARK);
               open_length = u2a_pkg::LEN_NONE;
               open_held = 2'd0;
            end else if (last_in_chunk) begin
               repeat (held) queue_char(u2a_pkg::QMARK);
               open_length = u2a_pkg::LEN_NONE;
               open_held = 2'd0;
            end else begin
               open_held = held[1:0];
            end
         end else begin
            // The breaking byte is handled again below as a fresh byte.
            repeat (open_held) queue_char(u2a_pkg::QMARK);
            open_length = u2a_pkg::LEN_NONE;
            open_held = 2'd0;
         end
      end
      if (fresh) begin
         if (!value[7]) begin
            queue_char(value[6:0]);
         end else begin
            if (value[7:5] == 3'b110)
               lead_length = u2a_pkg::LEN_TWO;
            else if (value[7:4] == 4'b1110)
               lead_length = u2a_pkg::LEN_THREE;
            else if (value[7:3] == 5'b11110)
               lead_length = u2a_pkg::LEN_FOUR;
            else
               lead_length = u2a_pkg::LEN_NONE;
            if (lead_length == u2a_pkg::LEN_NONE || last_in_chunk) begin
               queue_char(u2a_pkg::QMARK);
            end else begin
               open_length = lead_length;
               open_held = 2'd1;
            end
         end
      end
      if (expected_chars.size() > released) begin
         expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
         expected_chars[expected_chars.size() - 1].chunk_done = last_in_chunk;
      end
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last_in_chunk);
      while (!sender_steady && $urandom_range(99) < 28) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= value;
      req_chunk_end <= last_in_chunk;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_sanitized(value, last_in_chunk);
   endtask

   function automatic logic [7:0] lead_byte(input int length);
      logic [7:0] bits;
      bits = 8'($urandom);
      case (length)
         2: lead_byte = {3'b110, bits[4:0]};
         3: lead_byte = {4'b1110, bits[3:0]};
         default: lead_byte = {5'b11110, bits[2:0]};
      endcase
   endfunction

   function automatic logic [7:0] continuation_byte();
      logic [7:0] bits;
      bits = 8'($urandom);
      continuation_byte = {2'b10, bits[5:0]};
   endfunction

   function automatic logic random_chunk_end();
      random_chunk_end = ($urandom_range(99) < 8);
   endfunction

   // Receiver: checks each accepted character beat and decides the next pop.
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character %h with nothing pending", rsp_out_char);
            failures++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp_out_char);
               failures++;
            end
            if (rsp_last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run,
                      rsp_last_of_run);
               failures++;
            end
            if (rsp_chunk_done !== want.chunk_done) begin
               $error("chunk_done: expected %b, got %b", want.chunk_done,
                      rsp_chunk_done);
               failures++;
            end
         end
      end
      if (receiver_hold > 0) begin
         rsp_pop <= 1'b0;
         receiver_hold--;
      end else if (!receiver_steady && $urandom_range(99) < 28) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic test_ascii_passthrough();
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   task automatic test_stray_bytes();
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hFF, 1'b0);
   endtask

   task automatic test_complete_sequences();
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      // The final continuation completes the sequence exactly at chunk end.
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   task automatic test_broken_sequences();
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      // A new lead breaks the sequence and then opens one of its own.
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
   endtask

   task automatic test_chunk_end_cases();
      send_byte(8'hC3, 1'b1);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
   endtask

   task automatic test_backpressure();
      receiver_hold = 120;
      sender_steady = 1'b1;
      // Each group flushes three held bytes plus the breaking character.
      repeat (6) begin
         send_byte(8'hF0, 1'b0);
         send_byte(continuation_byte(), 1'b0);
         send_byte(continuation_byte(), 1'b0);
         send_byte(8'h41, 1'b0);
      end
      sender_steady = 1'b0;
   endtask

   task automatic test_random_stream(input int byte_count);
      int sent;
      int pick;
      int length;
      int seen;
      logic [7:0] breaker;
      sent = 0;
      while (sent < byte_count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_byte({1'b0, 7'($urandom)}, random_chunk_end());
            sent++;
         end else if (pick < 72) begin
            length = $urandom_range(4, 2);
            send_byte(lead_byte(length), random_chunk_end());
            repeat (length - 1) send_byte(continuation_byte(), random_chunk_end());
            sent += length;
         end else if (pick < 87) begin
            length = $urandom_range(4, 2);
            seen = $urandom_range(length - 2, 0);
            send_byte(lead_byte(length), 1'b0);
            repeat (seen) send_byte(continuation_byte(), 1'b0);
            case ($urandom_range(2))
               0: breaker = {1'b0, 7'($urandom)};
               1: breaker = lead_byte($urandom_range(4, 2));
               default: breaker = 8'($urandom_range(255, 248));
            endcase
            send_byte(breaker, random_chunk_end());
            sent += seen + 2;
         end else begin
            send_byte(8'($urandom_range(255)), random_chunk_end());
            sent++;
         end
      end
   endtask

   task automatic test_steady_stream();
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      test_random_stream(40);
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_ascii_passthrough();
      test_stray_bytes();
      test_complete_sequences();
      test_broken_sequences();
      test_chunk_end_cases();
      test_backpressure();
      test_steady_stream();
      test_random_stream(280);
      req_push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("utf8_to_ascii_sanitizer_core_test passed");
      end else begin
         $display("utf8_to_ascii_sanitizer_core_test failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("utf8_to_ascii_sanitizer_core_test failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: utf8_to_ascii_sanitizer_core.f
design/u2a_pkg.sv
design/u2a_front.sv
design/u2a_queue.sv
design/u2a_back.sv
design/utf8_to_ascii_sanitizer_core.sv
design/u2a_checker.sv
tb/sv/utf8_to_ascii_sanitizer_core_test.sv
